// ===== rtl/core/cube_map_face_select_macros.svh =====
// ----------------------------------------------------------------------------
// cube_map_face_select_macros
// Assertion macros shared by the port checker.
// ----------------------------------------------------------------------------
`ifndef CUBE_MAP_FACE_SELECT_MACROS_SVH
`define CUBE_MAP_FACE_SELECT_MACROS_SVH

// implication checked on every clock edge outside reset
`define CMFS_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("cmfs check failed");

// implication checked on the following clock edge, also across reset
`define CMFS_ASSERT_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("cmfs check failed");

`endif

// ===== rtl/core/cmfs_pkg.sv =====
// ----------------------------------------------------------------------------
// cmfs_pkg
// Shared types and constants for the cube map face select pipeline.
// ----------------------------------------------------------------------------
package cmfs_pkg;

    localparam int DIR_BITS      = 16;
    localparam int SIZE_BITS     = 13;
    localparam int COORD_BITS    = 12;
    localparam int FACE_BITS     = 3;
    localparam int MAX_FACE_SIZE = 4096;
    localparam int QUO_BITS      = 13;
    localparam int SUM_BITS      = DIR_BITS + 1;
    localparam int DEN_BITS      = DIR_BITS + 1;
    localparam int NUM_BITS      = SUM_BITS + SIZE_BITS;
    localparam int DIV_STAGES    = QUO_BITS;

    // face codes
    localparam logic [FACE_BITS-1:0] FACE_POS_X = 3'd0;
    localparam logic [FACE_BITS-1:0] FACE_NEG_X = 3'd1;
    localparam logic [FACE_BITS-1:0] FACE_POS_Y = 3'd2;
    localparam logic [FACE_BITS-1:0] FACE_NEG_Y = 3'd3;
    localparam logic [FACE_BITS-1:0] FACE_POS_Z = 3'd4;
    localparam logic [FACE_BITS-1:0] FACE_NEG_Z = 3'd5;

    // register indexes
    localparam logic [1:0] REG_FACE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FACE_HEIGHT = 2'd1;

    // operands handed to one divider
    typedef struct packed {
        logic [NUM_BITS-1:0] num;
        logic [DEN_BITS-1:0] den;
    } div_req_t;

    // side data that rides along the divider stages
    typedef struct packed {
        logic [FACE_BITS-1:0]  face;
        logic                  degen;
        logic [COORD_BITS-1:0] u_max;
        logic [COORD_BITS-1:0] v_max;
    } meta_t;

    // clamp a register value into 1..MAX_FACE_SIZE
    function automatic logic [SIZE_BITS-1:0] eff_size(input logic [SIZE_BITS-1:0] n);
        logic [SIZE_BITS-1:0] r;
        if (n == '0) begin
            r = SIZE_BITS'(1);
        end else if (n > SIZE_BITS'(MAX_FACE_SIZE)) begin
            r = SIZE_BITS'(MAX_FACE_SIZE);
        end else begin
            r = n;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/cmfs_divider.sv =====
// ----------------------------------------------------------------------------
// cmfs_divider
// Pipelined restoring divider, one quotient bit per stage, quotient < 2^13.
// ----------------------------------------------------------------------------
module cmfs_divider (
    input  logic                              aclk,
    input  logic                              en,
    input  cmfs_pkg::div_req_t                req,
    output logic [cmfs_pkg::QUO_BITS-1:0]     quo
);

    logic [cmfs_pkg::NUM_BITS-1:0] rem_reg [cmfs_pkg::DIV_STAGES];
    logic [cmfs_pkg::DEN_BITS-1:0] den_reg [cmfs_pkg::DIV_STAGES];
    logic [cmfs_pkg::QUO_BITS-1:0] quo_reg [cmfs_pkg::DIV_STAGES];

    for (genvar i = 0; i < cmfs_pkg::DIV_STAGES; i++) begin : g_stage
        localparam int K = cmfs_pkg::QUO_BITS - 1 - i;
        logic [cmfs_pkg::NUM_BITS-1:0] rem_in;
        logic [cmfs_pkg::DEN_BITS-1:0] den_in;
        logic [cmfs_pkg::QUO_BITS-1:0] quo_in;
        logic [cmfs_pkg::NUM_BITS-1:0] den_sh;
        logic                          ge;

        // stage inputs
        if (i == 0) begin : g_first
            assign rem_in = req.num;
            assign den_in = req.den;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = rem_reg[i-1];
            assign den_in = den_reg[i-1];
            assign quo_in = quo_reg[i-1];
        end

        // trial subtract of the shifted divisor
        assign den_sh = cmfs_pkg::NUM_BITS'(den_in) << K;
        assign ge     = (rem_in >= den_sh);

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i] <= ge ? (rem_in - den_sh) : rem_in;
                den_reg[i] <= den_in;
                quo_reg[i] <= ge ? (quo_in | (cmfs_pkg::QUO_BITS'(1) << K)) : quo_in;
            end
        end
    end

    assign quo = quo_reg[cmfs_pkg::DIV_STAGES-1];

endmodule

// ===== rtl/core/cube_map_face_select.sv =====
// A request passes the front stage, the product stage, 13 divide stages and
// the output register.
// Throughput: one request per cycle; the 13-stage bit-per-stage divider
// pair sets the depth. A stall at the output freezes the whole pipeline.
// Reset (aresetn low, synchronous) empties the pipeline and sets both
// face sizes to 256.
// ----------------------------------------------------------------------------
// cube_map_face_select
// Picks the cube face of a direction vector and its texel column and row.
// ----------------------------------------------------------------------------
module cube_map_face_select (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration writes
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [12:0] cfg_wdata,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // dir_x [15:0], dir_y [31:16], dir_z [47:32]
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // face [2:0], tex_u [14:3], tex_v [26:15], zero
    output logic        m_axis_tuser    // degenerate
);

    localparam int DB = cmfs_pkg::DIR_BITS;
    localparam int SB = cmfs_pkg::SUM_BITS;
    localparam int ZB = cmfs_pkg::SIZE_BITS;
    localparam int CB = cmfs_pkg::COORD_BITS;
    localparam int FB = cmfs_pkg::FACE_BITS;
    localparam int NS = cmfs_pkg::DIV_STAGES;

    logic en;

    // configuration registers
    logic [ZB-1:0] width_reg, height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= ZB'(256);
            height_reg <= ZB'(256);
        end else if (cfg_we) begin
            case (cfg_addr)
                cmfs_pkg::REG_FACE_WIDTH:  width_reg  <= cfg_wdata;
                cmfs_pkg::REG_FACE_HEIGHT: height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // front stage: major axis, face and signed s, t
    logic signed [DB-1:0] x, y, z;
    logic [DB-1:0]        ax, ay, az;
    logic [FB-1:0]        face_next;
    logic signed [SB-1:0] s_next, t_next;
    logic [DB-1:0]        m_next;

    assign x  = s_axis_tdata[DB-1:0];
    assign y  = s_axis_tdata[2*DB-1:DB];
    assign z  = s_axis_tdata[3*DB-1:2*DB];
    assign ax = x[DB-1] ? DB'(-x) : DB'(x);
    assign ay = y[DB-1] ? DB'(-y) : DB'(y);
    assign az = z[DB-1] ? DB'(-z) : DB'(z);

    always_comb begin
        if (ax >= ay && ax >= az) begin
            m_next = ax;
            t_next = -SB'(y);
            if (!x[DB-1]) begin
                face_next = cmfs_pkg::FACE_POS_X;
                s_next    = -SB'(z);
            end else begin
                face_next = cmfs_pkg::FACE_NEG_X;
                s_next    = SB'(z);
            end
        end else if (ay >= az) begin
            m_next = ay;
            s_next = SB'(x);
            if (!y[DB-1]) begin
                face_next = cmfs_pkg::FACE_POS_Y;
                t_next    = SB'(z);
            end else begin
                face_next = cmfs_pkg::FACE_NEG_Y;
                t_next    = -SB'(z);
            end
        end else begin
            m_next = az;
            t_next = -SB'(y);
            if (!z[DB-1]) begin
                face_next = cmfs_pkg::FACE_POS_Z;
                s_next    = SB'(x);
            end else begin
                face_next = cmfs_pkg::FACE_NEG_Z;
                s_next    = -SB'(x);
            end
        end
    end

    logic                 f_vld_reg;
    logic [FB-1:0]        f_face_reg;
    logic                 f_degen_reg;
    logic signed [SB-1:0] f_s_reg, f_t_reg;
    logic [DB-1:0]        f_m_reg;
    logic [ZB-1:0]        f_w_reg, f_h_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_vld_reg <= 1'b0;
        end else if (en) begin
            f_vld_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f_face_reg  <= face_next;
            f_degen_reg <= (ax == '0) && (ay == '0) && (az == '0);
            f_s_reg     <= s_next;
            f_t_reg     <= t_next;
            f_m_reg     <= m_next;
            f_w_reg     <= cmfs_pkg::eff_size(width_reg);
            f_h_reg     <= cmfs_pkg::eff_size(height_reg);
        end
    end

    // product stage: numerators (c + m) * n and divisor 2m
    logic [SB-1:0]        su, sv;
    logic                 p_vld_reg;
    cmfs_pkg::div_req_t   p_u_reg, p_v_reg;
    cmfs_pkg::meta_t      p_meta_reg;

    assign su = SB'(f_s_reg + $signed({1'b0, f_m_reg}));
    assign sv = SB'(f_t_reg + $signed({1'b0, f_m_reg}));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_vld_reg <= 1'b0;
        end else if (en) begin
            p_vld_reg <= f_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_u_reg.num      <= cmfs_pkg::NUM_BITS'(su * f_w_reg);
            p_u_reg.den      <= {f_m_reg, 1'b0};
            p_v_reg.num      <= cmfs_pkg::NUM_BITS'(sv * f_h_reg);
            p_v_reg.den      <= {f_m_reg, 1'b0};
            p_meta_reg.face  <= f_face_reg;
            p_meta_reg.degen <= f_degen_reg;
            p_meta_reg.u_max <= CB'(f_w_reg - ZB'(1));
            p_meta_reg.v_max <= CB'(f_h_reg - ZB'(1));
        end
    end

    // divider pair
    logic [cmfs_pkg::QUO_BITS-1:0] qu, qv;

    cmfs_divider u_div_u (.aclk(aclk), .en(en), .req(p_u_reg), .quo(qu));
    cmfs_divider u_div_v (.aclk(aclk), .en(en), .req(p_v_reg), .quo(qv));

    // side data alongside the divider
    logic            d_vld_reg  [NS];
    cmfs_pkg::meta_t d_meta_reg [NS];

    for (genvar i = 0; i < NS; i++) begin : g_meta
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                d_vld_reg[i] <= 1'b0;
            end else if (en) begin
                d_vld_reg[i] <= (i == 0) ? p_vld_reg : d_vld_reg[(i == 0) ? 0 : i-1];
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                d_meta_reg[i] <= (i == 0) ? p_meta_reg : d_meta_reg[(i == 0) ? 0 : i-1];
            end
        end
    end

    // clamp and output register
    cmfs_pkg::meta_t lm;
    logic [CB-1:0]   u_clamp, v_clamp;
    logic            o_vld_reg, o_degen_reg;
    logic [FB-1:0]   o_face_reg;
    logic [CB-1:0]   o_u_reg, o_v_reg;

    assign lm      = d_meta_reg[NS-1];
    assign u_clamp = (qu > cmfs_pkg::QUO_BITS'(lm.u_max)) ? lm.u_max : CB'(qu);
    assign v_clamp = (qv > cmfs_pkg::QUO_BITS'(lm.v_max)) ? lm.v_max : CB'(qv);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_vld_reg <= 1'b0;
        end else if (en) begin
            o_vld_reg <= d_vld_reg[NS-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            o_degen_reg <= lm.degen;
            o_face_reg  <= lm.degen ? cmfs_pkg::FACE_POS_X : lm.face;
            o_u_reg     <= lm.degen ? '0 : u_clamp;
            o_v_reg     <= lm.degen ? '0 : v_clamp;
        end
    end

    // pipeline advances unless a result waits
    assign en            = !o_vld_reg || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = o_vld_reg;
    assign m_axis_tdata  = {5'b0, o_v_reg, o_u_reg, o_face_reg};
    assign m_axis_tuser  = o_degen_reg;

endmodule

// ===== rtl/core/cmfs_checker.sv =====
// ----------------------------------------------------------------------------
// cmfs_port_checker
// Port-level checks for cube_map_face_select, bound to the top level.
// ----------------------------------------------------------------------------
`include "cube_map_face_select_macros.svh"

module cmfs_port_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    logic [2:0] face;
    logic       stall;
    assign face  = m_axis_tdata[2:0];
    assign stall = m_axis_tvalid && !m_axis_tready;

    // a stalled result holds
    `CMFS_ASSERT_IMPL(a_hold, aclk, aresetn, stall, ##1 (m_axis_tvalid && $stable(m_axis_tdata)))

    // zero vector result is all zero
    `CMFS_ASSERT_IMPL(a_degen, aclk, aresetn, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 32'd0)

    // face code in range
    `CMFS_ASSERT_IMPL(a_face, aclk, aresetn, m_axis_tvalid, face <= 3'd5)

    // pipeline empty right after reset
    `CMFS_ASSERT_NEXT(a_reset, aclk, !aresetn, !m_axis_tvalid)

endmodule

bind cube_map_face_select cmfs_port_checker u_cmfs_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== verif/cmfs_checker.sv =====
// ----------------------------------------------------------------------------
// cmfs_checker
// Watches the direction and result streams of cube_map_face_select, predicts
// face, texel column, texel row and the zero-vector flag of every accepted
// direction, and compares each result with the oldest prediction.
// ----------------------------------------------------------------------------
module cmfs_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [12:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    input  logic        m_axis_tuser,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [cmfs_pkg::FACE_BITS-1:0]  face;
        logic [cmfs_pkg::COORD_BITS-1:0] tex_u;
        logic [cmfs_pkg::COORD_BITS-1:0] tex_v;
        logic                            degenerate;
    } texel_t;

    logic [cmfs_pkg::SIZE_BITS-1:0] width_reg;
    logic [cmfs_pkg::SIZE_BITS-1:0] height_reg;
    texel_t                         texel_q[$];

    // clamp a size register into 1..MAX_FACE_SIZE
    function automatic longint clamp_size(input logic [cmfs_pkg::SIZE_BITS-1:0] n);
        longint r;
        r = n;
        if (r < 1) r = 1;
        if (r > cmfs_pkg::MAX_FACE_SIZE) r = cmfs_pkg::MAX_FACE_SIZE;
        return r;
    endfunction

    // floor((c + m) * n / (2m)) limited to n-1
    function automatic logic [cmfs_pkg::COORD_BITS-1:0] scale_coord(input longint c,
                                                                   input longint m,
                                                                   input longint n);
        longint q;
        q = ((c + m) * n) / (2 * m);
        if (q > n - 1) q = n - 1;
        return q[cmfs_pkg::COORD_BITS-1:0];
    endfunction

    function automatic texel_t select_texel(input logic [47:0] dir,
                                            input logic [cmfs_pkg::SIZE_BITS-1:0] wr,
                                            input logic [cmfs_pkg::SIZE_BITS-1:0] hr);
        longint x, y, z, ax, ay, az, m, s, t;
        texel_t r;
        x = longint'($signed(dir[15:0]));
        y = longint'($signed(dir[31:16]));
        z = longint'($signed(dir[47:32]));
        ax = x < 0 ? -x : x;
        ay = y < 0 ? -y : y;
        az = z < 0 ? -z : z;
        r = '0;
        if (ax == 0 && ay == 0 && az == 0) begin
            r.degenerate = 1'b1;
            return r;
        end
        // major axis, x wins ties then y
        if (ax >= ay && ax >= az) begin
            m = ax;
            t = -y;
            if (x >= 0) begin
                r.face = cmfs_pkg::FACE_POS_X;
                s = -z;
            end else begin
                r.face = cmfs_pkg::FACE_NEG_X;
                s = z;
            end
        end else if (ay >= az) begin
            m = ay;
            s = x;
            if (y >= 0) begin
                r.face = cmfs_pkg::FACE_POS_Y;
                t = z;
            end else begin
                r.face = cmfs_pkg::FACE_NEG_Y;
                t = -z;
            end
        end else begin
            m = az;
            t = -y;
            if (z >= 0) begin
                r.face = cmfs_pkg::FACE_POS_Z;
                s = x;
            end else begin
                r.face = cmfs_pkg::FACE_NEG_Z;
                s = -x;
            end
        end
        r.tex_u = scale_coord(s, m, clamp_size(wr));
        r.tex_v = scale_coord(t, m, clamp_size(hr));
        return r;
    endfunction

    assign pending = texel_q.size();

    // track registers, predict on input requests, check result requests
    always @(posedge aclk) begin
        texel_t got, want;
        if (!aresetn) begin
            width_reg  <= 13'd256;
            height_reg <= 13'd256;
            texel_q.delete();
            fail_count <= 0;
        end else begin
            if (cfg_we && cfg_addr == cmfs_pkg::REG_FACE_WIDTH) width_reg <= cfg_wdata;
            if (cfg_we && cfg_addr == cmfs_pkg::REG_FACE_HEIGHT) height_reg <= cfg_wdata;
            if (s_axis_tvalid && s_axis_tready)
                texel_q.push_back(select_texel(s_axis_tdata, width_reg, height_reg));
            if (m_axis_tvalid && m_axis_tready) begin
                got.face       = m_axis_tdata[2:0];
                got.tex_u      = m_axis_tdata[14:3];
                got.tex_v      = m_axis_tdata[26:15];
                got.degenerate = m_axis_tuser;
                if (texel_q.size() == 0) begin
                    $display("%0t: unexpected result, actual %h", $time, got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = texel_q.pop_front();
                    if (got.face !== want.face || got.tex_u !== want.tex_u ||
                        got.tex_v !== want.tex_v || got.degenerate !== want.degenerate ||
                        m_axis_tdata[31:27] !== 5'd0) begin
                        $display({"%0t: mismatch face/u/v/deg expected %0d/%0d/%0d/%0d",
                                  " actual %0d/%0d/%0d/%0d"},
                                 $time, want.face, want.tex_u, want.tex_v, want.degenerate,
                                 got.face, got.tex_u, got.tex_v, got.degenerate);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random direction vectors through cube_map_face_select
// under several face sizes with random gaps on both streams.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [12:0] cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;
    int          fail_count;
    int          pending;
    int          idle_cycles = 0;
    int          out_wait = 0;

    always #4 aclk = ~aclk;

    cube_map_face_select i_dut (.*);

    cmfs_checker i_checker (.*);

    // watchdog on cycles with no request on either stream
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // result back-pressure: a random wait after each accepted result
    always @(posedge aclk) begin
        int gap;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            out_wait      <= 0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            gap = $urandom_range(0, 12);
            out_wait      <= gap;
            m_axis_tready <= (gap == 0);
        end else if (out_wait > 0) begin
            out_wait      <= out_wait - 1;
            m_axis_tready <= (out_wait == 1);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // valid stays high across back-to-back requests
    task automatic send_dir(input logic [15:0] x, input logic [15:0] y, input logic [15:0] z,
                            input bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 12);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {z, y, x};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
    endtask

    task automatic write_size(input logic [1:0] idx, input logic [12:0] val);
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [15:0] rand_comp(input int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(0, 8)) - 4);
            2: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            default: return 16'($signed($urandom_range(0, 400)) - 200);
        endcase
    endfunction

    initial begin
        bit burst;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: zero vector, extremes, each face, ties
        send_dir(16'd0, 16'd0, 16'd0, 0);
        send_dir(16'h7FFF, 16'h8000, 16'h7FFF, 0);
        send_dir(16'h8000, 16'h7FFF, 16'h8000, 0);
        send_dir(16'h8000, 16'h8000, 16'h8000, 0);
        send_dir(16'h7FFF, 16'h7FFF, 16'h7FFF, 0);
        send_dir(16'd5, 16'd3, 16'hFFFE, 0);
        send_dir(16'hFFFB, 16'd3, 16'd2, 0);
        send_dir(16'd1, 16'd9, 16'hFFFA, 0);
        send_dir(16'd1, 16'hFFF7, 16'd6, 0);
        send_dir(16'd1, 16'd2, 16'd9, 0);
        send_dir(16'd1, 16'd2, 16'hFFF7, 0);
        send_dir(16'd4, 16'd4, 16'd0, 0);
        send_dir(16'd0, 16'hFFFC, 16'd4, 0);
        send_dir(16'd0, 16'd0, 16'h8000, 0);
        send_dir(16'd1, 16'd0, 16'd0, 0);

        // random phases over several face sizes, extremes included
        for (int phase = 0; phase < 7; phase++) begin
            case (phase)
                0: begin
                    write_size(cmfs_pkg::REG_FACE_WIDTH, 13'd0);
                    write_size(cmfs_pkg::REG_FACE_HEIGHT, 13'd1);
                end
                1: begin
                    write_size(cmfs_pkg::REG_FACE_WIDTH, 13'd4096);
                    write_size(cmfs_pkg::REG_FACE_HEIGHT, 13'h1FFF);
                end
                2: begin
                    write_size(cmfs_pkg::REG_FACE_WIDTH, 13'd4097);
                    write_size(cmfs_pkg::REG_FACE_HEIGHT, 13'd4095);
                end
                3: begin
                    write_size(cmfs_pkg::REG_FACE_WIDTH, 13'd3);
                    write_size(cmfs_pkg::REG_FACE_HEIGHT, 13'd7);
                end
                4: write_size(2'd2, 13'd5);
                5: write_size(2'd3, 13'h1555);
                default: begin
                    write_size(cmfs_pkg::REG_FACE_WIDTH, 13'($urandom));
                    write_size(cmfs_pkg::REG_FACE_HEIGHT, 13'($urandom_range(1, 4096)));
                end
            endcase
            for (int k = 0; k < 100; k++) begin
                burst = ($urandom_range(0, 3) == 0);
                send_dir(rand_comp($urandom_range(0, 3)), rand_comp($urandom_range(0, 3)),
                         rand_comp($urandom_range(0, 3)), burst);
            end
        end

        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
